[hw/rtl/sjd_pkg.sv]
// Shared types and constants for the skeleton junction detector.
`default_nettype none
package sjd_pkg;

    // configuration register map
    localparam int CFG_W            = 11;
    localparam int REG_IDX_W        = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] DEF_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] DEF_FRAME_HEIGHT = 11'd480;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_DIM        = 3;

    // stream payload
    localparam int PIX_W     = 8;
    localparam logic [PIX_W-1:0] PIX_SET = 8'hFF;
    localparam int IN_DATA_W = 8;
    localparam int IN_USER_W = 1;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int CNT_W     = 4;
    localparam int OUT_DATA_W = 24;

    localparam logic [CNT_W-1:0] MIN_NEIGHBOURS = 4'd3;
    localparam int RES_FIFO_DEPTH = 3;
    localparam int RES_FIFO_CW    = 2;

    // 3x3 window: bits 0..2 top row, 3..5 middle, 6..8 bottom, bit 0 newest column
    localparam int WIN_W = 9;
    localparam int WIN_CENTER = 4;
    localparam logic [WIN_W-1:0] WIN_SHIFT_MASK = 9'h1B6;

    typedef struct packed {
        logic [CNT_W-1:0] neighbour_count;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_result;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] count;
    } t_win_res;

endpackage
`default_nettype wire

[hw/rtl/sjd_line_mem.sv]
// Two-row line store (upper and middle bit per column) with post-reset clear sweep.
`default_nettype none
module sjd_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [1:0]         o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [1:0]    i_wr_data,
    output logic               o_busy
);
    import sjd_pkg::*;

    // bit 0: row r-2, bit 1: row r-1
    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_data;

    always_comb begin
        wr_en   = r_clr_busy | i_wr_en;
        wr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_clr_busy ? 2'b00 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule
`default_nettype wire

[hw/rtl/sjd_window.sv]
// 3x3 window register, neighbour popcount and junction test.
`default_nettype none
module sjd_window (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_test,
    input  wire logic       i_up,
    input  wire logic       i_mid,
    input  wire logic       i_cur,
    output sjd_pkg::t_win_res o_res
);
    import sjd_pkg::*;

    logic [WIN_W-1:0] r_win;
    logic [WIN_W-1:0] n_win;
    logic [CNT_W-1:0] count;

    always_comb begin
        n_win = ((r_win << 1) & WIN_SHIFT_MASK)
              | WIN_W'(i_up) | (WIN_W'(i_mid) << 3) | (WIN_W'(i_cur) << 6);
    end

    always_comb begin
        count = '0;
        for (int i = 0; i < WIN_W; i++) begin
            if (i != WIN_CENTER) begin
                count = count + CNT_W'(n_win[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        o_res.hit   = i_valid && i_test && n_win[WIN_CENTER] && (count >= MIN_NEIGHBOURS);
        o_res.count = count;
    end

endmodule
`default_nettype wire

[hw/rtl/sjd_out_fifo.sv]
// Small result queue decoupling the window stage from the output stream.
`default_nettype none
module sjd_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire sjd_pkg::t_result              i_data,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output sjd_pkg::t_result                   o_data,
    output logic [sjd_pkg::RES_FIFO_CW-1:0]    o_count
);
    import sjd_pkg::*;

    t_result r_buf [RES_FIFO_DEPTH];
    logic [RES_FIFO_CW-1:0] r_wr_ptr;
    logic [RES_FIFO_CW-1:0] r_rd_ptr;
    logic [RES_FIFO_CW-1:0] r_count;

    function automatic logic [RES_FIFO_CW-1:0] ptr_inc(input logic [RES_FIFO_CW-1:0] p);
        ptr_inc = (p == RES_FIFO_CW'(RES_FIFO_DEPTH - 1)) ? '0 : p + RES_FIFO_CW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + RES_FIFO_CW'(1);
                2'b01:   r_count <= r_count - RES_FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

[hw/rtl/skeleton_junction_detect.sv]
// Skeleton junction detector: streams a thinned image in raster order, one 8-bit
// pixel per cycle (only 255 counts as set), and emits column, row and neighbour
// count for every interior set pixel with three or more set 8-neighbours. An
// accepted pixel reads the line store at its accepting edge and is tested in the
// following cycle, so the result for the window that it closes enters the output
// queue at the end of that cycle and can be taken on the output from the cycle
// after that. One pixel is taken every cycle; outside the post-reset sweep the input
// stalls only while the three-entry result queue, counting the pixel under test,
// has no room left because the output stalls. After reset the line store is swept
// to zero over all MAX_WIDTH columns (1024 by default), during which o_s_axis_tready
// stays low; configuration writes are taken at any time.
`default_nettype none
module skeleton_junction_detect #(
    parameter int MAX_WIDTH  = sjd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sjd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [sjd_pkg::REG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sjd_pkg::CFG_W-1:0]        i_cfg_data,
    // pixel stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [sjd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // [7:0] pixel
    input  wire logic [sjd_pkg::IN_USER_W-1:0]    i_s_axis_tuser,  // [0] frame_start
    // junction stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [sjd_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata   // [9:0] col,
                                                                   // [19:10] row,
                                                                   // [23:20] neighbour_count
);
    import sjd_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int EH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    // configuration
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [EW-1:0]    w_raw, w_eff;
    logic [EH-1:0]    h_raw, h_eff;

    // position counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] c_cur;
    logic [RW-1:0] r_cur;
    logic [EW-1:0] c_nxt;
    logic [EH-1:0] r_nxt;
    logic          row_wrap;
    logic          test;
    logic          accept;

    // read stage
    logic          r_s1_valid;
    logic          r_s1_cur;
    logic          r_s1_test;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_fwd;
    logic [1:0]    r_fwd_data;
    logic [1:0]    mem_q;
    logic [1:0]    q_eff;
    logic [1:0]    wr_data;
    logic          mem_busy;

    t_win_res      win_res;
    t_result       res;
    t_result       fifo_data;
    logic          fifo_valid;
    logic [RES_FIFO_CW-1:0] fifo_count;
    logic [RES_FIFO_CW:0]   pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DEF_FRAME_WIDTH;
            r_frame_height <= DEF_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_raw = EW'(r_frame_width);
        h_raw = EH'(r_frame_height);
        w_eff = (w_raw < EW'(MIN_DIM)) ? EW'(MIN_DIM) :
                (w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw;
        h_eff = (h_raw < EH'(MIN_DIM)) ? EH'(MIN_DIM) :
                (h_raw > EH'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : h_raw;
    end

    always_comb begin
        c_cur    = i_s_axis_tuser[0] ? '0 : r_col;
        r_cur    = i_s_axis_tuser[0] ? '0 : r_row;
        c_nxt    = EW'(c_cur) + EW'(1);
        r_nxt    = EH'(r_cur) + EH'(1);
        row_wrap = (c_nxt >= w_eff);
        test     = (c_cur >= CW'(2)) && (EW'(c_cur) < w_eff)
                && (r_cur >= RW'(2)) && (EH'(r_cur) < h_eff);
    end

    // room for this request plus the one in the read stage
    assign pending         = {1'b0, fifo_count} + (RES_FIFO_CW + 1)'(r_s1_valid);
    assign o_s_axis_tready = !mem_busy && (pending <= (RES_FIFO_CW + 1)'(RES_FIFO_DEPTH - 1));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (row_wrap) begin
                    r_col <= '0;
                    r_row <= (r_nxt >= h_eff) ? '0 : RW'(r_nxt);
                end else begin
                    r_col <= CW'(c_nxt);
                    r_row <= r_cur;
                end
            end
        end
    end

    // back-to-back requests at the same column: the write below lands too late
    // for the new read, so the written bits are forwarded
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur   <= (i_s_axis_tdata[PIX_W-1:0] == PIX_SET);
            r_s1_test  <= test;
            r_s1_col   <= c_cur;
            r_s1_row   <= r_cur;
            r_s1_fwd   <= r_s1_valid && (c_cur == r_s1_col);
            r_fwd_data <= wr_data;
        end
    end

    assign q_eff   = r_s1_fwd ? r_fwd_data : mem_q;
    assign wr_data = {r_s1_cur, q_eff[1]};

    sjd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (c_cur),
        .o_rd_data (mem_q),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .o_busy    (mem_busy)
    );

    sjd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_test  (r_s1_test),
        .i_up    (q_eff[0]),
        .i_mid   (q_eff[1]),
        .i_cur   (r_s1_cur),
        .o_res   (win_res)
    );

    always_comb begin
        res.col             = COL_W'(r_s1_col - CW'(1));
        res.row             = ROW_W'(r_s1_row - RW'(1));
        res.neighbour_count = win_res.count;
    end

    sjd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (win_res.hit),
        .i_data  (res),
        .i_pop   (fifo_valid && i_m_axis_tready),
        .o_valid (fifo_valid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign o_m_axis_tvalid = fifo_valid;
    assign o_m_axis_tdata  = fifo_data;

endmodule
`default_nettype wire

[hw/rtl/sjd_checker.sv]
// Port-level checks for the skeleton junction detector, bound to the top level.
`default_nettype none
module sjd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [sjd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import sjd_pkg::*;

    // a stalled result request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result request dropped or changed while stalled");

    // a reported junction has between three and eight neighbours
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_DATA_W-1 -: CNT_W] >= MIN_NEIGHBOURS)
                         && (o_m_axis_tdata[OUT_DATA_W-1 -: CNT_W] <= CNT_W'(8)))
        else $error("neighbour count out of range");

    // reset empties the queue and holds off pixels for the line store sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("output or input handshake active right after reset");

endmodule

bind skeleton_junction_detect sjd_checker u_sjd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire

[tb/sv/skeleton_junction_detect_test.sv]
// Self-checking stream testbench for the skeleton junction detector.
`timescale 1ns / 1ps
module skeleton_junction_detect_test;
    import sjd_pkg::*;

    localparam int LINE_LEN      = DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 780;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             fs;
        logic             fixed;
        t_result          res;
    } t_pixel_row;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [REG_IDX_W-1:0]  i_cfg_idx       = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]      i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  i_s_axis_tuser  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    skeleton_junction_detect dut (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // shadow of the block: registers, line stores, window and raster position
    logic [CFG_W-1:0]    width_reg  = DEF_FRAME_WIDTH;
    logic [CFG_W-1:0]    height_reg = DEF_FRAME_HEIGHT;
    logic [LINE_LEN-1:0] line_upper  = '0;
    logic [LINE_LEN-1:0] line_middle = '0;
    logic [WIN_W-1:0]    win_bits    = '0;
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;

    t_result     junction_q[$];
    int unsigned err_cnt     = 0;
    int unsigned pixels_sent = 0;
    int unsigned burst_left  = 0;

    // 3x3 frame, both registers below the minimum so they clamp to 3
    t_pixel_row dir_rows [0:26] = '{
        // all set: centre has eight neighbours
        '{8'hFF, 1'b1, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{4'd8, 10'd1, 10'd1}},
        // three corners set, near-miss values elsewhere
        '{8'hFF, 1'b1, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFE, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'h7F, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, '{4'd3, 10'd1, 10'd1}},
        // no frame start: counters wrap; centre 254 is not set
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFE, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0}
    };

    function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void expect_junction(input t_result r);
        junction_q = {junction_q, r};
    endfunction

    function automatic void predict_junction(input logic [PIX_W-1:0] px, input logic fs,
                                             output bit hit, output t_result res);
        int unsigned w;
        int unsigned h;
        int unsigned nb;
        logic        cur;
        logic        up;
        logic        mid;
        w   = eff_dim(width_reg, DEF_MAX_WIDTH);
        h   = eff_dim(height_reg, DEF_MAX_HEIGHT);
        cur = (px == PIX_SET);
        hit = 1'b0;
        res = '0;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        up  = line_upper[col_pos];
        mid = line_middle[col_pos];
        // shift each window row toward the older columns, new column enters at the low bit
        win_bits = ((win_bits << 1) & 9'h1B6) | WIN_W'(up) | (WIN_W'(mid) << 3)
                   | (WIN_W'(cur) << 6);
        line_upper[col_pos]  = mid;
        line_middle[col_pos] = cur;
        if (col_pos >= 2 && col_pos < w && row_pos >= 2 && row_pos < h && win_bits[4]) begin
            nb = $countones(win_bits & ~9'h010);
            if (nb >= MIN_NEIGHBOURS) begin
                hit                 = 1'b1;
                res.col             = COL_W'(col_pos - 1);
                res.row             = ROW_W'(row_pos - 1);
                res.neighbour_count = CNT_W'(nb);
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
            end
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel(int unsigned density);
        if ($urandom_range(0, 99) < density) return PIX_SET;
        if ($urandom_range(0, 3) == 0) return 8'h00;
        return PIX_W'($urandom_range(0, 254));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic write_cfg(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_WIDTH;
        i_cfg_data <= w_raw;
        @(posedge i_clk);
        i_cfg_idx  <= REG_FRAME_HEIGHT;
        i_cfg_data <= h_raw;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_reg  = w_raw;
        height_reg = h_raw;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs,
                              input bit fixed, input t_result fixed_res);
        bit      hit;
        t_result res;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        i_s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_junction(px, fs, hit, res);
        if (fixed) begin
            expect_junction(fixed_res);
        end else if (hit) begin
            expect_junction(res);
        end
        pixels_sent++;
    endtask

    // registers change only once the pipeline is empty
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (junction_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                             input int unsigned n_px, input int unsigned density,
                             input bit clean_start, input bit noisy);
        logic fs;
        write_cfg(w_raw, h_raw);
        for (int unsigned i = 0; i < n_px; i++) begin
            fs = (i == 0) ? clean_start : (noisy && $urandom_range(0, 149) == 0);
            send_pixel(rand_pixel(density), fs, 1'b0, '0);
        end
        drain_results();
    endtask

    // receiver: alternating ready runs and stalls, some runs long
    int unsigned rx_left     = 0;
    bit          rx_stalling = 1'b1;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_stalling = !rx_stalling;
            if (rx_stalling) begin
                rx_left = $urandom_range(1, 8);
            end else begin
                rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
            end
        end
        rx_left--;
        i_m_axis_tready <= !rx_stalling;
    end

    always @(posedge i_clk) begin : junction_monitor
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata);
            if (junction_q.size() == 0) begin
                $error("unexpected junction: col %0d row %0d count %0d",
                       got.col, got.row, got.neighbour_count);
                err_cnt++;
            end else begin
                want = junction_q.pop_front();
                check_field("col", want.col, got.col);
                check_field("row", want.row, got.row);
                check_field("neighbour_count", want.neighbour_count, got.neighbour_count);
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        int unsigned      area;
        int unsigned      n_px;
        int unsigned      n_left;
        int unsigned      base;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(11'd0, 11'd2);
        for (int i = 0; i < $size(dir_rows); i++) begin
            send_pixel(dir_rows[i].px, dir_rows[i].fs, dir_rows[i].fixed, dir_rows[i].res);
        end
        drain_results();

        // leaves the column counter far out; the next phase may narrow the row under it
        run_phase(11'd1024, 11'd1024, $urandom_range(200, 400), 40, 1'b1, 1'b0);

        base = pixels_sent;
        while (pixels_sent - base < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w_raw = CFG_W'($urandom_range(0, 2));
                1:       w_raw = CFG_W'($urandom_range(17, 64));
                2:       w_raw = CFG_W'($urandom_range(1025, 2047));
                default: w_raw = CFG_W'($urandom_range(3, 16));
            endcase
            case ($urandom_range(0, 7))
                0:       h_raw = CFG_W'($urandom_range(0, 2));
                1:       h_raw = CFG_W'($urandom_range(1025, 2047));
                default: h_raw = CFG_W'($urandom_range(3, 12));
            endcase
            area = eff_dim(w_raw, DEF_MAX_WIDTH) * eff_dim(h_raw, DEF_MAX_HEIGHT);
            n_px = (area <= 600) ? area * $urandom_range(1, 2) + $urandom_range(0, 20)
                                 : $urandom_range(60, 300);
            n_left = RANDOM_PIXELS - (pixels_sent - base);
            if (n_px > n_left) begin
                n_px = n_left;
            end
            run_phase(w_raw, h_raw, n_px, $urandom_range(25, 70),
                      $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
        end

        if (err_cnt == 0) begin
            $display("skeleton_junction_detect_test: clean");
        end else begin
            $display("skeleton_junction_detect_test: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("skeleton_junction_detect_test: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sjd_pkg.sv
hw/rtl/sjd_line_mem.sv
hw/rtl/sjd_window.sv
hw/rtl/sjd_out_fifo.sv
hw/rtl/skeleton_junction_detect.sv
hw/rtl/sjd_checker.sv
tb/sv/skeleton_junction_detect_test.sv
